// ===== sv/audio_packet_reorder_window_defines.svh =====
// Assertion macros used by the reorder window back part.
// No dependencies.
`ifndef AUDIO_PACKET_REORDER_WINDOW_DEFINES_SVH
`define AUDIO_PACKET_REORDER_WINDOW_DEFINES_SVH
// implication checked every edge outside reset
`define APRW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define APRW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== sv/aprw_pkg.sv =====
// Package for the audio packet reorder window: constants, types, helpers.
// No dependencies.
package aprw_pkg;
  localparam int unsigned WindowDef = 16;
  localparam int unsigned SeqW = 16;
  localparam int unsigned HandleW = 32;
  localparam int unsigned GapW = 15;
  localparam int unsigned ConcW = 6;
  localparam int unsigned ConcealCap = 32;
  localparam logic [GapW-1:0] ResetGapRst = 15'd128;
  localparam logic [ConcW-1:0] MaxConcRst = 6'd8;
  localparam logic [0:0] RegResetGap = 1'b0;
  localparam logic [0:0] RegMaxConc = 1'b1;
  localparam logic FuncPush = 1'b0;
  localparam logic FuncClear = 1'b1;
  localparam logic KindPacket = 1'b0;
  localparam logic KindMissing = 1'b1;

  typedef enum logic [2:0] {
    StIdle, StDrain, StFindGap, StConceal, StFinish
  } back_state_e;

  // one queued request between front and back
  typedef struct packed {
    logic              func;
    logic [SeqW-1:0]   seq;
    logic [HandleW-1:0] handle;
  } req_t;
endpackage

// ===== sv/aprw_fifo.sv =====
// Two-entry request queue between front and back part.
// Depends on aprw_pkg.
module aprw_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  aprw_pkg::req_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output aprw_pkg::req_t rdata_o,
  output logic           empty_o
);
  aprw_pkg::req_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wp_q <= ~wp_q;
      if (pop_i && !empty_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i && !full_o} - {1'b0, pop_i && !empty_o};
    end
  end
endmodule

// ===== sv/aprw_back.sv =====
// Back part: holds the window store, drains it in order and skips gaps.
// Depends on aprw_pkg and the defines header.
`include "audio_packet_reorder_window_defines.svh"
module aprw_back #(
  parameter int unsigned Window = aprw_pkg::WindowDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [aprw_pkg::GapW-1:0]    reset_gap_i,
  input  logic [aprw_pkg::ConcW-1:0]   max_conceal_i,
  input  logic                         req_valid_i,
  input  aprw_pkg::req_t               req_i,
  output logic                         req_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         kind_o,
  output logic [aprw_pkg::SeqW-1:0]    out_seq_o,
  output logic [aprw_pkg::HandleW-1:0] out_handle_o,
  output logic                         last_o
);
  localparam int unsigned IdxW = (Window > 1) ? $clog2(Window) : 1;
  localparam int unsigned CntW = $clog2(Window + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Window - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Window);
  localparam int unsigned SW = aprw_pkg::SeqW;
  localparam int unsigned HW = aprw_pkg::HandleW;
  localparam int unsigned CW = aprw_pkg::ConcW;
  localparam logic [CW-1:0] CapMax = CW'(aprw_pkg::ConcealCap);

  aprw_pkg::back_state_e state_q, state_d;
  logic [Window-1:0] valid_q, valid_d;
  logic [SW-1:0]     seq_q [Window];
  logic [HW-1:0]     hdl_q [Window];
  logic              synced_q, synced_d;
  logic [SW-1:0]     exp_q, exp_d;
  logic [CntW-1:0]   held_q, held_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              have_q, have_d;
  logic [SW-1:0]     near_q, near_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  // pending result: held back until the next one exists or the request ends
  logic              pv_q, pv_d, pk_q, pk_d;
  logic [SW-1:0]     ps_q, ps_d;
  logic [HW-1:0]     ph_q, ph_d;
  // output register
  logic              ov_q, ov_d, ok_q, ok_d, ol_q, ol_d;
  logic [SW-1:0]     os_q, os_d;
  logic [HW-1:0]     oh_q, oh_d;

  logic              out_free, can_emit, emit, flush, wr_en;
  logic              e_kind;
  logic [SW-1:0]     e_seq;
  logic [HW-1:0]     e_hdl;
  logic [Window-1:0] base_valid, seq_match, exp_match;
  logic [IdxW-1:0]   free_idx, hit_idx;
  logic              hit, resync;
  logic [SW-1:0]     start_exp, dist_in, qd;
  logic [CW-1:0]     cap_w;

  assign out_free = !ov_q || out_ready_i;
  assign can_emit = !pv_q || out_free;

  always_comb begin
    for (int i = 0; i < int'(Window); i++) begin
      seq_match[i] = seq_q[i] == req_i.seq;
      exp_match[i] = valid_q[i] && (seq_q[i] == exp_q);
    end
  end

  // classify the request at the queue head
  assign start_exp  = synced_q ? exp_q : req_i.seq;
  assign dist_in    = req_i.seq - start_exp;
  assign resync     = !dist_in[SW-1] && (dist_in > {1'b0, reset_gap_i});
  assign base_valid = resync ? '0 : valid_q;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = int'(Window) - 1; i >= 0; i--) begin
      if (!base_valid[i]) free_idx = IdxW'(i);
    end
  end

  // slot holding the expected number
  always_comb begin
    hit_idx = '0;
    for (int i = int'(Window) - 1; i >= 0; i--) begin
      if (exp_match[i]) hit_idx = IdxW'(i);
    end
  end
  assign hit = |exp_match;

  assign qd    = seq_q[idx_q] - exp_q;
  assign cap_w = (max_conceal_i > CapMax) ? CapMax : max_conceal_i;

  always_comb begin
    state_d = state_q; valid_d = valid_q; synced_d = synced_q; exp_d = exp_q;
    held_d = held_q; idx_d = idx_q; have_d = have_q; near_d = near_q; cnt_d = cnt_q;
    req_pop_o = 1'b0; wr_en = 1'b0; emit = 1'b0; flush = 1'b0;
    e_kind = aprw_pkg::KindPacket; e_seq = '0; e_hdl = '0;
    unique case (state_q)
      aprw_pkg::StIdle: begin
        if (req_valid_i) begin
          req_pop_o = 1'b1;
          if (req_i.func == aprw_pkg::FuncClear) begin
            valid_d = '0; synced_d = 1'b0; exp_d = '0; held_d = '0;
          end else begin
            synced_d = 1'b1;
            exp_d = start_exp;
            if (!dist_in[SW-1]) begin
              if (resync) begin
                exp_d = req_i.seq; valid_d = '0; held_d = '0;
              end
              // duplicates of a held number are dropped
              if ((base_valid & seq_match) == '0) begin
                wr_en = 1'b1;
                valid_d = base_valid;
                valid_d[free_idx] = 1'b1;
                held_d = (resync ? '0 : held_q) + CntW'(1);
                state_d = aprw_pkg::StDrain;
              end
            end
          end
        end
      end
      aprw_pkg::StDrain: begin
        if (hit) begin
          if (can_emit) begin
            emit = 1'b1; e_kind = aprw_pkg::KindPacket; e_seq = exp_q;
            e_hdl = hdl_q[hit_idx];
            valid_d[hit_idx] = 1'b0; held_d = held_q - CntW'(1);
            exp_d = exp_q + SW'(1);
          end
        end else if (held_q == FullCnt) begin
          state_d = aprw_pkg::StFindGap; idx_d = '0; have_d = 1'b0; near_d = '0;
        end else begin
          state_d = aprw_pkg::StFinish;
        end
      end
      aprw_pkg::StFindGap: begin
        if (valid_q[idx_q] && qd != '0 && !qd[SW-1] && (!have_q || qd < near_q)) begin
          near_d = qd; have_d = 1'b1;
        end
        if (idx_q == LastIdx) begin
          idx_d = '0;
          if (have_d) begin
            state_d = aprw_pkg::StConceal; cnt_d = '0;
          end else begin
            state_d = aprw_pkg::StFinish;
          end
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      aprw_pkg::StConceal: begin
        if (({{(SW-CW){1'b0}}, cnt_q} < near_q) && (cnt_q < cap_w)) begin
          if (can_emit) begin
            emit = 1'b1; e_kind = aprw_pkg::KindMissing;
            e_seq = exp_q + {{(SW-CW){1'b0}}, cnt_q}; e_hdl = '0;
            cnt_d = cnt_q + CW'(1);
          end
        end else begin
          exp_d = exp_q + near_q; state_d = aprw_pkg::StDrain;
        end
      end
      aprw_pkg::StFinish: begin
        // the pending result is the final one of this request
        if (!pv_q) begin
          state_d = aprw_pkg::StIdle;
        end else if (out_free) begin
          flush = 1'b1; state_d = aprw_pkg::StIdle;
        end
      end
      default: state_d = aprw_pkg::StIdle;
    endcase
  end

  always_comb begin
    pv_d = pv_q; pk_d = pk_q; ps_d = ps_q; ph_d = ph_q;
    ov_d = ov_q && !out_ready_i; ok_d = ok_q; os_d = os_q; oh_d = oh_q; ol_d = ol_q;
    if (emit) begin
      if (pv_q) begin
        ov_d = 1'b1; ok_d = pk_q; os_d = ps_q; oh_d = ph_q; ol_d = 1'b0;
      end
      pv_d = 1'b1; pk_d = e_kind; ps_d = e_seq; ph_d = e_hdl;
    end else if (flush) begin
      ov_d = 1'b1; ok_d = pk_q; os_d = ps_q; oh_d = ph_q; ol_d = 1'b1; pv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      seq_q[free_idx] <= req_i.seq;
      hdl_q[free_idx] <= req_i.handle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aprw_pkg::StIdle; valid_q <= '0; synced_q <= 1'b0; exp_q <= '0;
      held_q <= '0; idx_q <= '0; have_q <= 1'b0; near_q <= '0; cnt_q <= '0;
      pv_q <= 1'b0; pk_q <= 1'b0; ps_q <= '0; ph_q <= '0;
      ov_q <= 1'b0; ok_q <= 1'b0; ol_q <= 1'b0; os_q <= '0; oh_q <= '0;
    end else begin
      state_q <= state_d; valid_q <= valid_d; synced_q <= synced_d; exp_q <= exp_d;
      held_q <= held_d; idx_q <= idx_d; have_q <= have_d; near_q <= near_d;
      cnt_q <= cnt_d;
      pv_q <= pv_d; pk_q <= pk_d; ps_q <= ps_d; ph_q <= ph_d;
      ov_q <= ov_d; ok_q <= ok_d; ol_q <= ol_d; os_q <= os_d; oh_q <= oh_d;
    end
  end

  assign out_valid_o  = ov_q;
  assign kind_o       = ok_q;
  assign out_seq_o    = os_q;
  assign out_handle_o = oh_q;
  assign last_o       = ol_q;

  `APRW_ASSERT_IMP(a_held_bound, 1'b1, held_q <= FullCnt, "held count above window")
  `APRW_ASSERT_IMP(a_pop_idle, req_pop_o, state_q == aprw_pkg::StIdle,
                   "request taken while busy")
  `APRW_ASSERT_NXT(a_clear, req_pop_o && req_i.func == aprw_pkg::FuncClear,
                   valid_q == '0 && !synced_q, "clear left state")
  `APRW_ASSERT_IMP(a_idle_flushed, state_q == aprw_pkg::StIdle, !pv_q,
                   "pending result left at idle")
  `APRW_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(kind_o) && $stable(out_seq_o) &&
                   $stable(out_handle_o) && $stable(last_o),
                   "result changed while stalled")
endmodule

// ===== sv/audio_packet_reorder_window.sv =====
// Top level of the audio packet reorder window: APB registers, queue, back part.
// Depends on aprw_pkg, aprw_fifo, aprw_back.
//
//  channel | dir | handshake          | payload
//  in      | in  | in_valid/in_ready  | func, seq_number, payload_handle
//  out     | out | out_valid/out_ready| kind, out_seq, out_handle, last
//  cfg     | in  | psel/penable/pwrite| paddr, pwdata, prdata
//
// A request is taken into a two-entry queue and reaches the back part when it is idle.
// Classify and store happen in the idle state; clears and drops end there. A stored
// packet then releases held packets in order, finds no further match and passes
// a finish state; a full store adds a gap search over every slot, missing markers
// and a return to draining. Reset clears valid bits and sync at once.
// Results wait in a pending and an output register; a stalled output holds the
// back part and a full queue stalls the input.
module audio_packet_reorder_window #(
  parameter int unsigned Window = aprw_pkg::WindowDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [15:0] seq_number_i,
  input  logic [31:0] payload_handle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [15:0] out_seq_o,
  output logic [31:0] out_handle_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [aprw_pkg::GapW-1:0]  reset_gap_q;
  logic [aprw_pkg::ConcW-1:0] max_conceal_q;
  aprw_pkg::req_t req_w, req_r;
  logic full, empty, pop;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_gap_q <= aprw_pkg::ResetGapRst; max_conceal_q <= aprw_pkg::MaxConcRst;
    end else if (psel && penable && pwrite) begin
      if (paddr == {aprw_pkg::RegResetGap, 2'b00}) reset_gap_q <= pwdata[14:0];
      else if (paddr == {aprw_pkg::RegMaxConc, 2'b00}) max_conceal_q <= pwdata[5:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr == {aprw_pkg::RegResetGap, 2'b00}) prdata = {17'd0, reset_gap_q};
    else if (paddr == {aprw_pkg::RegMaxConc, 2'b00}) prdata = {26'd0, max_conceal_q};
  end

  assign req_w = '{func: func_i, seq: seq_number_i, handle: payload_handle_i};
  assign in_ready_o = !full;

  aprw_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(in_valid_i), .wdata_i(req_w), .full_o(full),
    .pop_i(pop), .rdata_o(req_r), .empty_o(empty)
  );

  aprw_back #(.Window(Window)) u_back (
    .clk_i, .rst_ni, .reset_gap_i(reset_gap_q), .max_conceal_i(max_conceal_q),
    .req_valid_i(!empty), .req_i(req_r), .req_pop_o(pop),
    .out_valid_o, .out_ready_i, .kind_o, .out_seq_o, .out_handle_o, .last_o
  );
endmodule
